### design/tpc_pkg.sv
// Shared types, constants and arithmetic helpers for the triangle plane clipper.
package tpc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_PLANE   = 4;
    localparam int FIFO_DEPTH  = 2;
    localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_D = 3'd3;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic signed [31:0] tex_s;
        logic signed [31:0] tex_t;
        logic signed [31:0] tex_r;
        logic signed [31:0] tex_q;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic signed [31:0] out_s;
        logic signed [31:0] out_t;
        logic signed [31:0] out_r;
        logic signed [31:0] out_q;
        logic               last_vertex;
    } out_word_t;

    // Vertex viewed as eight words; element 7 is pos_x.
    typedef logic [7:0][WORD_W-1:0] vec_t;

    typedef struct packed {
        vec_t               vtx;
        logic signed [31:0] plane_dist;
    } q_entry_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < SAT_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Polygon corner for each emitted vertex of the fan (0,1,2) and (0,2,3).
    function automatic logic [1:0] fan_corner(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd2;
            3'd5:    r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

### design/triangle_plane_clipper_top.sv
// Top level of the triangle plane clipper: front end, queue and back end.
// Front end: a vertex is accepted, then its plane distance is computed on one
// multiplier; no new vertex is taken until the last one has gone into the queue.
// Back end: 3 queue reads, one step per edge, a FRAC_BITS-bit restoring division and a
// multiply and an add per field for each crossing (at most two crossings), then one
// output word a cycle while out_ready allows it.
// Reset (rst_n, asynchronous) clears plane registers, vertex count and queue.
module triangle_plane_clipper_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpc_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tpc_pkg::vertex_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tpc_pkg::out_word_t            out_data
);

    logic              push_valid, push_ready, pop_valid, pop_ready;
    tpc_pkg::q_entry_t push_data, pop_data;

    tpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tpc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### design/tpc_front.sv
// Front end: holds the plane, accepts vertices and computes their plane distance.
module tpc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpc_pkg::WORD_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tpc_pkg::vertex_t               in_data,
    output logic                           push_valid,
    input  logic                           push_ready,
    output tpc_pkg::q_entry_t              push_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [2:0]               k_reg, k_next;
    logic signed [33:0]       acc_reg, acc_next;
    logic signed [63:0]       prod_reg;
    logic signed [31:0]       plane_reg [tpc_pkg::NUM_PLANE];
    tpc_pkg::vec_t            vtx_reg;
    logic [2:0]               fld_idx;
    logic signed [31:0]       term;

    // Plane coefficient registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tpc_pkg::NUM_PLANE; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpc_pkg::REG_PLANE_A: plane_reg[0] <= cfg_wdata;
                tpc_pkg::REG_PLANE_B: plane_reg[1] <= cfg_wdata;
                tpc_pkg::REG_PLANE_C: plane_reg[2] <= cfg_wdata;
                tpc_pkg::REG_PLANE_D: plane_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_data.vtx        = vtx_reg;
    assign push_data.plane_dist = tpc_pkg::sat32(64'(acc_reg));

    assign fld_idx = 3'd7 - k_reg;
    assign term    = tpc_pkg::sat32(prod_reg >>> tpc_pkg::FRAC_BITS);

    // Dot product sequencer: one product a cycle, each registered and then added to the accumulator.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                    k_next     = '0;
                    acc_next   = '0;
                end
            end
            ST_CALC:
            begin
                if (k_reg != 3'd0)
                begin
                    acc_next = acc_reg + 34'(term);
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_valid && in_ready)
        begin
            vtx_reg <= tpc_pkg::vec_t'(in_data);
        end
        if (state_reg == ST_CALC && k_reg != 3'd4)
        begin
            prod_reg <= 64'($signed(vtx_reg[fld_idx])) * 64'(plane_reg[k_reg[1:0]]);
        end
    end

endmodule

### design/tpc_fifo.sv
// Short queue of classified vertices between the front and back ends.
module tpc_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  tpc_pkg::q_entry_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output tpc_pkg::q_entry_t pop_data
);

    localparam int PTR_W = $clog2(tpc_pkg::FIFO_DEPTH);

    tpc_pkg::q_entry_t           mem [tpc_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]            wptr_reg, rptr_reg;
    logic [PTR_W:0]              count_reg;
    logic                        do_push, do_pop;

    assign push_ready = (count_reg != PTR_W'(0) + (PTR_W+1)'(tpc_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

    // Pointers wrap naturally at a power-of-two depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

### design/tpc_back.sv
// Back end: gathers triangles, clips against the plane and emits the fan.
module tpc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  tpc_pkg::q_entry_t pop_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tpc_pkg::out_word_t out_data
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_EDGE = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam int F = tpc_pkg::FRAC_BITS;

    logic [2:0]                  state_reg;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  edge_reg;
    logic [2:0]                  pcount_reg;
    logic [2:0]                  fld_reg;
    logic [2:0]                  k_reg;
    logic [tpc_pkg::DIV_CNT_W-1:0] bit_reg;
    tpc_pkg::vec_t               tri_reg  [3];
    logic signed [31:0]          dist_reg [3];
    tpc_pkg::vec_t               poly_reg [4];
    tpc_pkg::vec_t               lin_reg, lout_reg;
    logic [32:0]                 diff_reg;
    logic [32:0]                 rem_reg;
    logic [F-1:0]                q_reg;
    logic signed [63:0]          prod_reg;
    logic                        out_valid_reg;
    tpc_pkg::out_word_t          out_reg;

    logic [1:0]                  ia, ib;
    logic                        in_a, in_b, keep, crossing;
    logic [2:0]                  cnt_after;
    logic signed [33:0]          diff_full;
    logic [33:0]                 rem_sh;
    logic                        q_bit;
    logic signed [32:0]          fdiff;
    logic signed [31:0]          lerp_res;
    logic [2:0]                  n_out;
    logic                        last;
    logic                        out_free;

    // Edge endpoints: v2-v0, v0-v1, v1-v2.
    assign ia        = (edge_reg == 2'd0) ? 2'd2 : edge_reg - 2'd1;
    assign ib        = edge_reg;
    assign in_a      = !dist_reg[ia][31];
    assign in_b      = !dist_reg[ib][31];
    assign keep      = in_a && (pcount_reg < 3'd4);
    assign cnt_after = keep ? pcount_reg + 3'd1 : pcount_reg;
    assign crossing  = (in_a != in_b) && (cnt_after < 3'd4);
    assign diff_full = in_a ? 34'(dist_reg[ia]) - 34'(dist_reg[ib])
                            : 34'(dist_reg[ib]) - 34'(dist_reg[ia]);

    // One restoring division step; the quotient is known to stay below one.
    assign rem_sh = {rem_reg, 1'b0};
    assign q_bit  = (rem_sh >= {1'b0, diff_reg});

    // Interpolation of one field from the inside end.
    assign fdiff    = 33'($signed(lout_reg[fld_reg])) - 33'($signed(lin_reg[fld_reg]));
    assign lerp_res = tpc_pkg::sat32(64'($signed(lin_reg[fld_reg])) + (prod_reg >>> F));

    assign n_out    = (pcount_reg == 3'd4) ? 3'd6 : 3'd3;
    assign last     = (k_reg == n_out - 3'd1);
    assign out_free = !out_valid_reg || out_ready;

    assign pop_ready = (state_reg == ST_LOAD);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Control sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            edge_reg      <= '0;
            pcount_reg    <= '0;
            fld_reg       <= '0;
            k_reg         <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (pop_valid)
                    begin
                        if (cnt_reg == 2'd2 || cnt_reg == 2'd3)
                        begin
                            cnt_reg    <= '0;
                            edge_reg   <= '0;
                            pcount_reg <= '0;
                            state_reg  <= ST_EDGE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 2'd1;
                        end
                    end
                end
                ST_EDGE:
                begin
                    pcount_reg <= cnt_after;
                    if (crossing)
                    begin
                        bit_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                    else if (edge_reg == 2'd2)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        edge_reg <= edge_reg + 2'd1;
                    end
                end
                ST_DIV:
                begin
                    bit_reg <= bit_reg + tpc_pkg::DIV_CNT_W'(1);
                    if (bit_reg == tpc_pkg::DIV_CNT_W'(F - 1))
                    begin
                        fld_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    fld_reg <= fld_reg + 3'd1;
                    if (fld_reg == 3'd7)
                    begin
                        pcount_reg <= pcount_reg + 3'd1;
                        if (edge_reg == 2'd2)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            edge_reg  <= edge_reg + 2'd1;
                            state_reg <= ST_EDGE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_EMIT:
                begin
                    if (pcount_reg < 3'd3)
                    begin
                        state_reg <= ST_LOAD;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        k_reg         <= k_reg + 3'd1;
                        if (last)
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && pop_valid)
        begin
            tri_reg[(cnt_reg == 2'd3) ? 2'd2 : cnt_reg]  <= pop_data.vtx;
            dist_reg[(cnt_reg == 2'd3) ? 2'd2 : cnt_reg] <= pop_data.plane_dist;
        end
        if (state_reg == ST_EDGE)
        begin
            if (keep)
            begin
                poly_reg[pcount_reg[1:0]] <= tri_reg[ia];
            end
            if (crossing)
            begin
                lin_reg  <= in_a ? tri_reg[ia] : tri_reg[ib];
                lout_reg <= in_a ? tri_reg[ib] : tri_reg[ia];
                rem_reg  <= in_a ? 33'($unsigned(dist_reg[ia]))
                                 : 33'($unsigned(dist_reg[ib]));
                diff_reg <= diff_full[32:0];
                q_reg    <= '0;
            end
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= q_bit ? 33'(rem_sh - {1'b0, diff_reg}) : rem_sh[32:0];
            q_reg   <= {q_reg[F-2:0], q_bit};
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 64'(fdiff) * 64'($signed({1'b0, q_reg}));
        end
        if (state_reg == ST_ADD)
        begin
            poly_reg[pcount_reg[1:0]][fld_reg] <= lerp_res;
        end
        if (state_reg == ST_EMIT && pcount_reg >= 3'd3 && out_free)
        begin
            out_reg <= tpc_pkg::out_word_t'({poly_reg[tpc_pkg::fan_corner(k_reg)], last});
        end
    end

endmodule

### design/tpc_checker.sv
// Port-level checks for the triangle plane clipper, bound to the top level.
module tpc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input tpc_pkg::out_word_t out_data
);

    logic [2:0] run_reg;

    // Words delivered so far in the current output run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            run_reg <= out_data.last_vertex ? 3'd0 : run_reg + 3'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("vertex accepted during distance computation");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_vertex |-> run_reg == 3'd2 || run_reg == 3'd5)
        else $error("output run does not end after three or six words");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_vertex |-> run_reg < 3'd5)
        else $error("output run longer than six words");

endmodule

bind triangle_plane_clipper_top tpc_checker u_tpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
